// ----- rtl/owbm_pkg.sv -----
// owbm_pkg: shared types and constants of the one-wire bus master
// used by owbm_cfg, owbm_core and the top level; no dependencies
package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int TIMER_W       = 10;
  localparam int EDGE_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_RESET = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;
  localparam logic [1:0] FUNC_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_READ_REST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE          = 3'd5;

  typedef struct packed {
    logic [TIMER_W-1:0] reset_low_ticks;
    logic [TIMER_W-1:0] reset_release_ticks;
    logic [TIMER_W-1:0] write_hold_ticks;
    logic [TIMER_W-1:0] read_sample_ticks;
    logic [TIMER_W-1:0] read_rest_ticks;
    logic [EDGE_W-1:0]  edge_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       rejected;
  } res_t;

endpackage

// ----- rtl/owbm_cfg.sv -----
// owbm_cfg: timing register file of the one-wire bus master
// depends on owbm_pkg
module owbm_cfg
  import owbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= TIMER_W'(500);
      cfg.reset_release_ticks <= TIMER_W'(500);
      cfg.write_hold_ticks    <= TIMER_W'(30);
      cfg.read_sample_ticks   <= TIMER_W'(14);
      cfg.read_rest_ticks     <= TIMER_W'(45);
      cfg.edge_ticks          <= EDGE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     cfg.reset_low_ticks     <= cfg_data;
        REG_RESET_RELEASE: cfg.reset_release_ticks <= cfg_data;
        REG_WRITE_HOLD:    cfg.write_hold_ticks    <= cfg_data;
        REG_READ_SAMPLE:   cfg.read_sample_ticks   <= cfg_data;
        REG_READ_REST:     cfg.read_rest_ticks     <= cfg_data;
        REG_EDGE:          cfg.edge_ticks          <= cfg_data[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/owbm_core.sv -----
// owbm_core: bus operation state and the per-beat step logic
// depends on owbm_pkg; driven by the top level's input register
module owbm_core
  import owbm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PIN_RELEASED = 2'd0,
    PIN_LOW      = 2'd1,
    PIN_HIGH     = 2'd2
  } pin_t;

  typedef struct packed {
    pin_t               pin;
    logic [TIMER_W-1:0] timer;
  } setup_t;

  op_t                  op, op_next;
  logic [2:0]           phase, phase_next;
  logic [TIMER_W-1:0]   timer, timer_next;
  logic [7:0]           shift, shift_next;
  logic [BIT_IDX_W-1:0] bit_idx, bit_idx_next;
  pin_t                 pin, pin_next;
  logic [7:0]           last_read, last_read_next;

  function automatic logic [TIMER_W-1:0] load_timer(input logic [TIMER_W-1:0] t);
    return (t == '0) ? TIMER_W'(1) : t;
  endfunction

  function automatic setup_t phase_setup(input op_t o, input logic [2:0] p,
                                         input logic lsb, input cfg_t c);
    setup_t s;
    s.pin   = PIN_LOW;
    s.timer = load_timer(TIMER_W'(c.edge_ticks));
    case (o)
      OP_RESET: begin
        if (p == 3'd0) begin
          s.timer = load_timer(c.reset_low_ticks);
        end else begin
          s.pin   = PIN_RELEASED;
          s.timer = load_timer(c.reset_release_ticks);
        end
      end
      OP_WRITE: begin
        if (p == 3'd1) begin
          s.pin   = lsb ? PIN_HIGH : PIN_LOW;
          s.timer = load_timer(c.write_hold_ticks);
        end else if (p != 3'd0) begin
          s.pin = PIN_HIGH;
        end
      end
      default: begin
        if (p == 3'd1) begin
          s.pin   = PIN_RELEASED;
          s.timer = load_timer(c.read_sample_ticks);
        end else if (p == 3'd2) begin
          s.pin   = PIN_RELEASED;
          s.timer = load_timer(c.read_rest_ticks);
        end else if (p != 3'd0) begin
          s.pin = PIN_HIGH;
        end
      end
    endcase
    return s;
  endfunction

  logic [TIMER_W-1:0] timer_dec;
  logic [7:0]         shift_mod;
  logic               last_bit;
  logic               done;
  logic               rej;
  setup_t             su;

  assign timer_dec = (timer != '0) ? timer - TIMER_W'(1) : '0;
  assign last_bit  = (bit_idx == BIT_IDX_W'(BITS_PER_BYTE - 1));

  always_comb begin
    op_next        = op;
    phase_next     = phase;
    timer_next     = timer;
    shift_next     = shift;
    bit_idx_next   = bit_idx;
    pin_next       = pin;
    last_read_next = last_read;
    done           = 1'b0;
    rej            = 1'b0;
    shift_mod      = shift;
    su             = phase_setup(op, phase + 3'd1, shift[0], cfg);
    if (step) begin
      if (item.func == FUNC_TICK) begin
        if (op != OP_IDLE) begin
          timer_next = timer_dec;
          if (timer_dec == '0) begin
            if (op == OP_WRITE && phase >= 3'd2) begin
              shift_mod = shift >> 1;
            end else if (op == OP_READ && phase == 3'd1) begin
              shift_mod = {item.line_level, shift[7:1]};
            end
            shift_next = shift_mod;
            if ((op == OP_RESET && phase == 3'd0) ||
                (op == OP_WRITE && phase < 3'd2) ||
                (op == OP_READ && phase < 3'd3)) begin
              phase_next = phase + 3'd1;
              pin_next   = su.pin;
              timer_next = su.timer;
            end else if (op == OP_RESET) begin
              op_next    = OP_IDLE;
              phase_next = 3'd0;
              done       = 1'b1;
            end else if (last_bit) begin
              // end of byte
              op_next      = OP_IDLE;
              phase_next   = 3'd0;
              timer_next   = '0;
              bit_idx_next = '0;
              done         = 1'b1;
              if (op == OP_READ) begin
                last_read_next = shift_mod;
              end
            end else begin
              bit_idx_next = bit_idx + BIT_IDX_W'(1);
              phase_next   = 3'd0;
              pin_next     = PIN_LOW;
              timer_next   = load_timer(TIMER_W'(cfg.edge_ticks));
            end
          end
        end
      end else if (op != OP_IDLE) begin
        rej = 1'b1;
      end else begin
        op_next      = op_t'(item.func);
        bit_idx_next = '0;
        shift_next   = (item.func == FUNC_WRITE) ? item.data_byte : 8'd0;
        phase_next   = 3'd0;
        pin_next     = PIN_LOW;
        timer_next   = (item.func == FUNC_RESET) ? load_timer(cfg.reset_low_ticks)
                                                 : load_timer(TIMER_W'(cfg.edge_ticks));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op        <= OP_IDLE;
      phase     <= '0;
      timer     <= '0;
      shift     <= '0;
      bit_idx   <= '0;
      pin       <= PIN_RELEASED;
      last_read <= '0;
    end else begin
      op        <= op_next;
      phase     <= phase_next;
      timer     <= timer_next;
      shift     <= shift_next;
      bit_idx   <= bit_idx_next;
      pin       <= pin_next;
      last_read <= last_read_next;
    end
  end

  assign res.drive_enable = (pin_next != PIN_RELEASED);
  assign res.drive_level  = (pin_next == PIN_HIGH);
  assign res.busy_res     = (op_next != OP_IDLE);
  assign res.done_res     = done;
  assign res.read_byte    = last_read_next;
  assign res.rejected     = rej;

endmodule

// ----- rtl/one_wire_bus_master.sv -----
// one_wire_bus_master: top level with input register, core and result register
// depends on owbm_pkg, owbm_cfg and owbm_core
//
// One-wire bus master. Each input beat is a microsecond tick (func 0) or a
// command (bus reset, write byte, read byte) and gives exactly one result beat
// with the pin drive and status. Throughput is one beat per clock while the
// result is not stalled; an accepted beat passes the input register, then the
// step logic into the result register. A stalled result holds back the input
// register only, so one more beat is taken while a result waits. The user must
// write the timing registers (cfg_we/cfg_index/cfg_data) only while the block is
// idle; the block does not enforce this. Indexes beyond 5 are ignored.
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            func,
  input  logic [7:0]            data_byte,
  input  logic                  line_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  drive_enable,
  output logic                  drive_level,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [7:0]            read_byte,
  output logic                  rejected
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res;
  res_t  res_q;
  logic  step;
  logic  in_take;

  assign step     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owbm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      item_valid <= in_take || (item_valid && !step);
      out_valid  <= step || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= '{func: func, data_byte: data_byte, line_level: line_level};
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign drive_enable = res_q.drive_enable;
  assign drive_level  = res_q.drive_level;
  assign busy_res     = res_q.busy_res;
  assign done_res     = res_q.done_res;
  assign read_byte    = res_q.read_byte;
  assign rejected     = res_q.rejected;

endmodule

// ----- rtl/owbm_checker.sv -----
// owbm_checker: port-level assertions on the one-wire bus master results
// bound to one_wire_bus_master; depends on owbm_pkg
module owbm_checker
  import owbm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       drive_enable,
  input logic       drive_level,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_byte,
  input logic       rejected
);

  // a finished operation leaves the master idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done beat shows busy");

  // a command is only turned away while an operation runs
  assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res && !done_res)
    else $error("rejected beat while not busy");

  // released line reports no driven level
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive_enable |-> !drive_level)
    else $error("level driven while released");

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_byte) && $stable(busy_res))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .drive_enable (drive_enable),
  .drive_level  (drive_level),
  .busy_res     (busy_res),
  .done_res     (done_res),
  .read_byte    (read_byte),
  .rejected     (rejected)
);
